[rtl/ifla_pkg.sv]
// ----------------------------------------------------------------------------
// ifla_pkg
// Shared types and constants of the inode free list allocator.
// ----------------------------------------------------------------------------
package ifla_pkg;

  localparam int INO_W  = 10;
  localparam int WORD_W = 32;

  typedef logic [1:0]        status_t;
  typedef logic [INO_W-1:0]  ino_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_INUSE = 2'd2;

  localparam ino_t COUNT_MAX = '1;

  // outcome of one read-modify-write step
  typedef struct packed {
    logic    wr_en;
    logic    head_load;
    logic    gen_load;
    logic    count_up;
    logic    count_down;
    status_t status;
    ino_t    result_inode;
    word_t   generation;
    word_t   entry_version;
  } upd_res_t;

endpackage

[rtl/ifla_if.sv]
// ----------------------------------------------------------------------------
// ifla_in_if / ifla_out_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface ifla_in_if import ifla_pkg::*;;
  logic  valid;
  logic  ready;
  logic  operation;
  ino_t  inode_number;
  word_t now_seconds;

  modport source (output valid, operation, inode_number, now_seconds, input ready);
  modport sink   (input valid, operation, inode_number, now_seconds, output ready);
endinterface

interface ifla_out_if import ifla_pkg::*;;
  logic    valid;
  logic    ready;
  status_t status;
  ino_t    result_inode;
  word_t   generation;
  word_t   entry_version;
  ino_t    files_in_use;

  modport source (output valid, status, result_inode, generation, entry_version,
                  files_in_use, input ready);
  modport sink   (input valid, status, result_inode, generation, entry_version,
                  files_in_use, output ready);
endinterface

[rtl/ifla_ram.sv]
// ----------------------------------------------------------------------------
// ifla_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ifla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/ifla_update.sv]
// ----------------------------------------------------------------------------
// ifla_update
// Modify step: decides an allocate or free from the entry read back and
// builds the entry to write, the new list head and the result item.
// ----------------------------------------------------------------------------
module ifla_update import ifla_pkg::*; #(
  parameter int INODE_COUNT = 1024,
  localparam int IW = $clog2(INODE_COUNT),
  localparam int EW = IW + 1 + 2 * WORD_W
) (
  input  logic          operation,
  input  ino_t          inode_number,
  input  word_t         now_seconds,
  input  logic [IW-1:0] head,
  input  word_t         gen_count,
  input  logic [EW-1:0] rd_word,
  output logic [EW-1:0] wr_word,
  output logic [IW-1:0] wr_addr,
  output logic [IW-1:0] new_head,
  output upd_res_t      res
);

  localparam int CW = ((IW > INO_W) ? IW : INO_W) + 1;
  localparam logic [IW:0]   HEAD_LIM = (IW + 1)'(INODE_COUNT);
  localparam logic [CW-1:0] INO_LIM  = CW'(INODE_COUNT);

  logic [IW-1:0] ent_next;
  logic          ent_in_use;
  word_t         ent_version;
  word_t         ent_atime;
  word_t         gen_inc;
  word_t         gen_new;
  word_t         ver_inc;
  logic [CW-1:0] ino_ext;
  logic [IW-1:0] ino_idx;

  assign ent_next    = rd_word[EW-1 -: IW];
  assign ent_in_use  = rd_word[2*WORD_W];
  assign ent_version = rd_word[2*WORD_W-1 -: WORD_W];
  assign ent_atime   = rd_word[WORD_W-1:0];

  assign gen_inc = gen_count + 32'd1;
  assign gen_new = (gen_inc < now_seconds) ? now_seconds : gen_inc;
  assign ver_inc = ent_version + 32'd1;
  assign ino_ext = CW'(inode_number);
  assign ino_idx = IW'(inode_number);

  always_comb begin
    res      = '0;
    wr_word  = rd_word;
    wr_addr  = head;
    new_head = head;
    res.status = ST_OK;
    if (operation == OP_ALLOC) begin
      if (head == '0 || {1'b0, head} >= HEAD_LIM) begin
        res.status = ST_EMPTY;
      end else if (ent_in_use) begin
        res.status = ST_INUSE;
      end else begin
        res.wr_en         = 1'b1;
        res.head_load     = 1'b1;
        res.gen_load      = 1'b1;
        res.count_up      = 1'b1;
        new_head          = ent_next;
        wr_word           = {ent_next, 1'b1, ent_version, now_seconds};
        res.result_inode  = INO_W'(head);
        res.generation    = gen_new;
        res.entry_version = ent_version;
      end
    end else begin
      wr_addr = ino_idx;
      if (ino_ext != '0 && ino_ext < INO_LIM) begin
        res.wr_en         = 1'b1;
        res.head_load     = 1'b1;
        res.count_down    = 1'b1;
        new_head          = ino_idx;
        wr_word           = {head, 1'b0, ver_inc, ent_atime};
        res.result_inode  = inode_number;
        res.entry_version = ver_inc;
      end
    end
  end

endmodule

[rtl/inode_free_list_allocator.sv]
// flow: an accepted item reads its entry into the entry memory's read register,
//   then in S_EXEC its result is loaded into the output register once that is free;
//   a new item is taken only in S_IDLE, after the previous one has committed
// reset: clears control state, then sweeps all INODE_COUNT entries of the entry
//   memory (chain, in-use marks, versions) with in_if.ready low
// ----------------------------------------------------------------------------
// inode_free_list_allocator
// LIFO free list allocator over an inode table held in one entry memory.
// ----------------------------------------------------------------------------
module inode_free_list_allocator import ifla_pkg::*; #(
  parameter int INODE_COUNT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  ifla_in_if.sink   in_if,
  ifla_out_if.source out_if
);

  localparam int IW = $clog2(INODE_COUNT);
  localparam int EW = IW + 1 + 2 * WORD_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(INODE_COUNT - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [IW-1:0] head_r, head_nxt;
  word_t         gen_r, gen_nxt;
  ino_t          count_r, count_nxt;

  logic          op_r;
  ino_t          ino_r;
  word_t         now_r;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r;
  ino_t          out_ino_r;
  word_t         out_gen_r;
  word_t         out_ver_r;
  ino_t          out_count_r;

  logic          accept;
  logic          commit;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] rd_word;
  logic [EW-1:0] upd_word;
  logic [IW-1:0] upd_addr;
  logic [IW-1:0] upd_head;
  logic [EW-1:0] init_word;
  upd_res_t      res;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign commit      = (state_r == S_EXEC) && (!out_valid_r || out_if.ready);

  assign ram_raddr = (in_if.operation == OP_ALLOC) ? head_r : IW'(in_if.inode_number);
  assign init_word = {((clr_cnt_r == LAST_IDX) ? IW'(0) : clr_cnt_r + IW'(1)),
                      1'b0, 32'd0, 32'd0};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = upd_addr;
    ram_wdata = upd_word;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = init_word;
    end else if (commit) begin
      ram_we = res.wr_en;
    end
  end

  ifla_ram #(
    .WIDTH(EW),
    .DEPTH(INODE_COUNT)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(ram_raddr),
    .rdata(rd_word)
  );

  ifla_update #(
    .INODE_COUNT(INODE_COUNT)
  ) u_update (
    .operation   (op_r),
    .inode_number(ino_r),
    .now_seconds (now_r),
    .head        (head_r),
    .gen_count   (gen_r),
    .rd_word     (rd_word),
    .wr_word     (upd_word),
    .wr_addr     (upd_addr),
    .new_head    (upd_head),
    .res         (res)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    head_nxt    = head_r;
    gen_nxt     = gen_r;
    count_nxt   = count_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
          if (res.head_load) begin
            head_nxt = upd_head;
          end
          if (res.gen_load) begin
            gen_nxt = res.generation;
          end
          if (res.count_up && count_r < COUNT_MAX) begin
            count_nxt = count_r + INO_W'(1);
          end else if (res.count_down && count_r != '0) begin
            count_nxt = count_r - INO_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      head_r      <= IW'(1);
      gen_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      gen_r       <= gen_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_if.operation;
      ino_r <= in_if.inode_number;
      now_r <= in_if.now_seconds;
    end
    if (commit) begin
      out_status_r <= res.status;
      out_ino_r    <= res.result_inode;
      out_gen_r    <= res.generation;
      out_ver_r    <= res.entry_version;
      out_count_r  <= count_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.result_inode  = out_ino_r;
  assign out_if.generation    = out_gen_r;
  assign out_if.entry_version = out_ver_r;
  assign out_if.files_in_use  = out_count_r;

  // entry memory is written only by the sweep or by a committing step
  a_ram_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR) || commit)
    else $error("entry memory written outside sweep or commit");

  // read data must hold while a step waits on the result register
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && $past(state_r == S_EXEC) |-> $stable(rd_word))
    else $error("entry read data changed while waiting");

  // the file count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) || (count_r == $past(count_r) + INO_W'(1))
                     || (count_r == $past(count_r) - INO_W'(1)))
    else $error("file count jumped");

  // a result loaded in the first cycle of a step follows an item taken the cycle before
  a_commit_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    commit && $past(state_r == S_IDLE) |-> $past(accept))
    else $error("commit without an accepted item");

endmodule
